// ----- rtl/assert_macros.svh -----
// Assertion macros for the alignment score core checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SWA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define SWA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/swa_pkg.sv -----
// Types, widths and codes shared by the alignment score core.
package swa_pkg;

    localparam int QUERY_MAX     = 1024;
    localparam int ALPHABET_SIZE = 32;

    localparam int POS_W     = $clog2(QUERY_MAX);
    localparam int RES_W     = $clog2(ALPHABET_SIZE);
    localparam int CNT_W     = $clog2(QUERY_MAX + 1);
    localparam int PSC_W     = 8;
    localparam int PEN_W     = 8;
    localparam int QLEN_W    = 11;
    localparam int SCORE_W   = 18;
    localparam int E_W       = SCORE_W + 1;
    localparam int CALC_W    = SCORE_W + 2;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam int IN_FIELDS_W = POS_W + RES_W + PSC_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SCORE_W + 7) / 8) * 8;

    localparam logic [SCORE_W-1:0] SCORE_MAX      = '1;
    localparam logic [PEN_W-1:0]   GAP_OPEN_RST   = 8'd10;
    localparam logic [PEN_W-1:0]   GAP_EXTEND_RST = 8'd2;
    localparam logic [QLEN_W-1:0]  QLEN_RST       = QLEN_W'(QUERY_MAX);

    // Item kinds carried in tuser
    localparam logic FUNC_PROFILE = 1'b0;
    localparam logic FUNC_RESIDUE = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP_OPEN   = 2'd0,
        CFG_GAP_EXTEND = 2'd1,
        CFG_QUERY_LEN  = 2'd2
    } cfg_idx_t;

    // Gap penalties broadcast to every cell
    typedef struct packed {
        logic [PEN_W-1:0]        q;
        logic [PEN_W-1:0]        r;
        logic [PEN_W:0]          m;
        logic signed [E_W-1:0]   neg_q;
    } gap_cfg_t;

    // One beat moving from cell to cell along the row
    typedef struct packed {
        logic                       valid;
        logic                       func;
        logic                       last;
        logic                       fresh;
        logic [RES_W-1:0]           residue;
        logic [CNT_W-1:0]           count;
        logic signed [PSC_W-1:0]    pscore;
        logic [SCORE_W-1:0]         h;
        logic [SCORE_W-1:0]         diag;
        logic signed [E_W-1:0]      f;
        logic [SCORE_W-1:0]         best;
    } token_t;

endpackage

// ----- rtl/swa_cell.sv -----
// One query position of the systolic row: profile column, H/E state and column maximum.
module swa_cell import swa_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     advance,
    input  gap_cfg_t gap_cfg,
    input  token_t   tok_in,
    output token_t   tok_out
);

    logic signed [PSC_W-1:0] prof_reg [ALPHABET_SIZE];
    logic [SCORE_W-1:0]      h_reg;
    logic signed [E_W-1:0]   e_reg;
    logic [SCORE_W-1:0]      max_reg;
    token_t                  tok_reg;
    token_t                  tok_next;

    logic                     active;
    logic [SCORE_W-1:0]       h_old;
    logic signed [E_W-1:0]    e_old;
    logic [SCORE_W-1:0]       max_old;
    logic signed [PSC_W-1:0]  p_score;
    logic signed [CALC_W-1:0] r_c, m_c;
    logic signed [CALC_W-1:0] f_a, f_b, f_new;
    logic signed [CALC_W-1:0] e_a, e_b, e_new;
    logic signed [CALC_W-1:0] d_sum, h_0, h_1, h_2;
    logic [SCORE_W-1:0]       h_new;
    logic [SCORE_W-1:0]       max_act;
    logic [SCORE_W-1:0]       h_upd;
    logic signed [E_W-1:0]    e_upd;
    logic [SCORE_W-1:0]       max_upd;

    // Pick the state this row starts from; a new sequence starts from cleared values
    always_comb begin
        active  = (tok_in.count != '0);
        h_old   = tok_in.fresh ? '0 : h_reg;
        e_old   = tok_in.fresh ? gap_cfg.neg_q : e_reg;
        max_old = tok_in.fresh ? '0 : max_reg;
        p_score = prof_reg[tok_in.residue];
    end

    // Gotoh recurrence for this position
    always_comb begin
        r_c   = $signed({{(CALC_W-PEN_W){1'b0}}, gap_cfg.r});
        m_c   = $signed({{(CALC_W-PEN_W-1){1'b0}}, gap_cfg.m});
        f_a   = CALC_W'(tok_in.f) - r_c;
        f_b   = $signed({2'b00, tok_in.h}) - m_c;
        f_new = (f_b > f_a) ? f_b : f_a;
        e_a   = CALC_W'(e_old) - r_c;
        e_b   = $signed({2'b00, h_old}) - m_c;
        e_new = (e_b > e_a) ? e_b : e_a;
        d_sum = $signed({2'b00, tok_in.diag}) + CALC_W'(p_score);
        h_0   = d_sum[CALC_W-1] ? '0 : d_sum;
        h_1   = (f_new > h_0) ? f_new : h_0;
        h_2   = (e_new > h_1) ? e_new : h_1;
        h_new = (h_2 > $signed({2'b00, SCORE_MAX})) ? SCORE_MAX : h_2[SCORE_W-1:0];
        max_act = (h_new > max_old) ? h_new : max_old;
    end

    // Inactive positions keep their state but still take the sequence-start clear
    always_comb begin
        h_upd   = active ? h_new : h_old;
        e_upd   = active ? e_new[E_W-1:0] : e_old;
        max_upd = active ? max_act : max_old;
    end

    // Build the beat handed to the next cell
    always_comb begin
        tok_next = tok_in;
        if (tok_in.func == FUNC_PROFILE || active) begin
            tok_next.count = tok_in.count - CNT_W'(1);
        end else begin
            tok_next.count = '0;
        end
        if (tok_in.func == FUNC_RESIDUE && active) begin
            tok_next.h    = h_new;
            tok_next.diag = h_old;
            tok_next.f    = f_new[E_W-1:0];
        end
        tok_next.best = (tok_in.best > max_upd) ? tok_in.best : max_upd;
    end

    // Update profile column or row state when a beat passes
    always_ff @(posedge aclk) begin
        if (advance && tok_in.valid) begin
            if (tok_in.func == FUNC_PROFILE) begin
                if (tok_in.count == '0) begin
                    prof_reg[tok_in.residue] <= tok_in.pscore;
                end
            end else begin
                h_reg   <= h_upd;
                e_reg   <= e_upd;
                max_reg <= max_upd;
            end
        end
    end

    // Hand the beat on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else if (advance) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- rtl/smith_waterman_affine_score_core.sv -----
// Local alignment score core with affine gaps, built as a row of QUERY_MAX cells.
// A beat passes the QUERY_MAX cell registers and then the output register to its result beat.
// Throughput: one beat per cycle; the whole row holds while a result beat waits on m_tready.
// Reset clears control and loads default penalties; the first residue after reset or
// after a last-flagged residue clears H, E and column maxima as it passes each cell.
module smith_waterman_affine_score_core import swa_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,   // position, residue, profile_score, zero pad
    input  logic                  s_tuser,   // func
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // best_score, zero pad
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wr_data
);

    logic [PEN_W-1:0]   q_reg;
    logic [PEN_W-1:0]   r_reg;
    logic [QLEN_W-1:0]  qlen_reg;
    logic               fresh_reg, fresh_next;
    logic               out_valid_reg, out_valid_next;
    logic [SCORE_W-1:0] out_score_reg, out_score_next;
    logic [CNT_W-1:0]   n_eff;
    logic               advance;
    logic               in_acc;
    gap_cfg_t           gap_cfg;
    token_t             in_tok;
    token_t             chain [0:QUERY_MAX];

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg    <= GAP_OPEN_RST;
            r_reg    <= GAP_EXTEND_RST;
            qlen_reg <= QLEN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_GAP_OPEN:   q_reg    <= cfg_wr_data[PEN_W-1:0];
                CFG_GAP_EXTEND: r_reg    <= cfg_wr_data[PEN_W-1:0];
                CFG_QUERY_LEN:  qlen_reg <= cfg_wr_data[QLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the query length to the row, treating zero as one
    always_comb begin
        if (qlen_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (int'(qlen_reg) > QUERY_MAX) begin
            n_eff = CNT_W'(QUERY_MAX);
        end else begin
            n_eff = CNT_W'(qlen_reg);
        end
    end

    // Penalties for every cell
    always_comb begin
        gap_cfg.q     = q_reg;
        gap_cfg.r     = r_reg;
        gap_cfg.m     = {1'b0, q_reg} + {1'b0, r_reg};
        gap_cfg.neg_q = -$signed({{(E_W-PEN_W){1'b0}}, q_reg});
    end

    // Advance the whole row unless a result waits on a stalled output
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign in_acc   = s_tvalid && s_tready;

    // Form the beat entering the first cell
    always_comb begin
        in_tok.valid   = in_acc;
        in_tok.func    = s_tuser;
        in_tok.last    = s_tlast;
        in_tok.fresh   = fresh_reg;
        in_tok.residue = s_tdata[POS_W +: RES_W];
        in_tok.pscore  = $signed(s_tdata[POS_W+RES_W +: PSC_W]);
        in_tok.count   = (s_tuser == FUNC_PROFILE) ? CNT_W'(s_tdata[POS_W-1:0]) : n_eff;
        in_tok.h       = '0;
        in_tok.diag    = '0;
        in_tok.f       = gap_cfg.neg_q;
        in_tok.best    = '0;
    end

    // Mark the start of a new database sequence
    always_comb begin
        fresh_next = fresh_reg;
        if (in_acc && s_tuser == FUNC_RESIDUE) begin
            fresh_next = s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fresh_reg <= 1'b1;
        end else begin
            fresh_reg <= fresh_next;
        end
    end

    assign chain[0] = in_tok;

    // Row of cells, one per query position
    for (genvar gi = 0; gi < QUERY_MAX; gi++) begin : g_cell
        swa_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .gap_cfg (gap_cfg),
            .tok_in  (chain[gi]),
            .tok_out (chain[gi+1])
        );
    end

    // Capture the score of a last-flagged residue leaving the row
    always_comb begin
        out_valid_next = out_valid_reg;
        out_score_next = out_score_reg;
        if (advance) begin
            out_valid_next = chain[QUERY_MAX].valid && chain[QUERY_MAX].last &&
                             (chain[QUERY_MAX].func == FUNC_RESIDUE);
            out_score_next = chain[QUERY_MAX].best;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_score_reg <= out_score_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_score_reg);

endmodule

// ----- rtl/swa_checker.sv -----
// Port-level checks for the alignment score core, bound to the top level.
`include "assert_macros.svh"

module swa_checker import swa_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   s_tuser,
    input logic                   s_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [CNT_W:0] pending_reg, pending_next;
    logic           last_in;
    logic           out_beat;

    // Count last-flagged residues whose score has not yet left
    assign last_in  = s_tvalid && s_tready && (s_tuser == FUNC_RESIDUE) && s_tlast;
    assign out_beat = m_tvalid && m_tready;

    always_comb begin
        pending_next = pending_reg;
        if (last_in && !out_beat) begin
            pending_next = pending_reg + (CNT_W+1)'(1);
        end else if (!last_in && out_beat) begin
            pending_next = pending_reg - (CNT_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    `SWA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat dropped or changed while stalled")
    `SWA_ASSERT(a_stall_cause, aclk, aresetn, !s_tready |-> (m_tvalid && !m_tready), "input stalled without output backpressure")
    `SWA_ASSERT(a_result_owed, aclk, aresetn, m_tvalid |-> (pending_reg != '0), "result beat without a pending last residue")
    `SWA_ASSERT(a_score_pad, aclk, aresetn, m_tvalid |-> (m_tdata[OUT_TDATA_W-1:SCORE_W] == '0), "result pad bits not zero")

endmodule

bind smith_waterman_affine_score_core swa_checker u_swa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- dv/tb_smith_waterman_affine_score_core.sv -----
// Self-checking testbench for the affine-gap local alignment score core.
`timescale 1ns / 100ps

module tb_smith_waterman_affine_score_core;
    import swa_pkg::*;

    // Registers from an accepted beat to its result: the cell row plus the output register
    localparam int PIPE_LATENCY = QUERY_MAX + 1;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;   // position, residue, profile_score, zero pad
    logic                   s_tuser = 1'b0; // func
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // best_score, zero pad
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr = CFG_GAP_OPEN;
    logic [CFG_W-1:0]       cfg_wr_data = '0;

    smith_waterman_affine_score_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // Predictor copy of the penalty registers
    logic [PEN_W-1:0]  gap_q    = GAP_OPEN_RST;
    logic [PEN_W-1:0]  gap_r    = GAP_EXTEND_RST;
    logic [QLEN_W-1:0] qlen_reg = QLEN_RST;

    // Predictor copy of the score profile and the alignment rows
    logic signed [PSC_W-1:0] profile_col [ALPHABET_SIZE][QUERY_MAX];
    bit                      col_written [ALPHABET_SIZE][QUERY_MAX];
    int                      written_len [ALPHABET_SIZE];
    int                      row_h [QUERY_MAX];
    int                      row_e [QUERY_MAX];
    int                      seq_best = 0;
    bit                      seq_fresh = 1'b1;

    logic [SCORE_W-1:0] pending_scores [$];
    logic [SCORE_W-1:0] want_score;

    bit steady_flow = 1'b0;
    int n_residues = 0;
    int n_profile = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_settings = 0;

    // Query positions a row actually covers
    function automatic int active_length();
        if (qlen_reg == 0)
            return 1;
        if (qlen_reg > QUERY_MAX)
            return QUERY_MAX;
        return int'(qlen_reg);
    endfunction

    function automatic void record_profile(input logic [RES_W-1:0] res,
                                           input logic [POS_W-1:0] pos,
                                           input logic [PSC_W-1:0] psc);
        profile_col[res][pos] = psc;
        col_written[res][pos] = 1'b1;
        while (written_len[res] < QUERY_MAX && col_written[res][written_len[res]])
            written_len[res]++;
    endfunction

    // Advance H and E by one database residue and track the running maximum
    function automatic void score_row(input logic [RES_W-1:0] res);
        int n, q, r, m, hleft, diag, f, e, h;
        q = int'(gap_q);
        r = int'(gap_r);
        m = q + r;
        if (seq_fresh) begin
            foreach (row_h[j]) begin
                row_h[j] = 0;
                row_e[j] = -q;
            end
            seq_best = 0;
            seq_fresh = 1'b0;
        end
        n = active_length();
        hleft = 0;
        diag = 0;
        f = -q;
        for (int j = 0; j < n; j++) begin
            f = (hleft - m > f - r) ? hleft - m : f - r;
            e = (row_h[j] - m > row_e[j] - r) ? row_h[j] - m : row_e[j] - r;
            h = diag + int'(profile_col[res][j]);
            if (h < 0)
                h = 0;
            if (h < f)
                h = f;
            if (h < e)
                h = e;
            if (h > int'(SCORE_MAX))
                h = int'(SCORE_MAX);
            diag = row_h[j];
            row_h[j] = h;
            row_e[j] = e;
            hleft = h;
            if (h > seq_best)
                seq_best = h;
        end
    endfunction

    // Pick a residue whose profile column covers the active query length
    function automatic logic [RES_W-1:0] pick_residue();
        int start, n;
        n = active_length();
        start = $urandom_range(0, ALPHABET_SIZE - 1);
        for (int k = 0; k < ALPHABET_SIZE; k++) begin
            if (written_len[(start + k) % ALPHABET_SIZE] >= n)
                return RES_W'((start + k) % ALPHABET_SIZE);
        end
        return RES_W'(ALPHABET_SIZE - 1);
    endfunction

    // Drive one input beat; called and returning at a falling edge
    task automatic send_beat(input logic func, input logic [POS_W-1:0] pos,
                             input logic [RES_W-1:0] res, input logic [PSC_W-1:0] psc,
                             input logic last);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tlast  <= last;
        s_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, psc, res, pos};
        do @(posedge aclk); while (!s_tready);
        // Beat accepted: update the predictor
        if (func == FUNC_PROFILE) begin
            record_profile(res, pos, psc);
            n_profile++;
        end else begin
            score_row(res);
            n_residues++;
            if (last) begin
                pending_scores.push_back(SCORE_W'(seq_best));
                seq_fresh = 1'b1;
            end
        end
        @(negedge aclk);
    endtask

    task automatic write_profile(input int res, input int pos, input int psc);
        send_beat(FUNC_PROFILE, POS_W'(pos), RES_W'(res), PSC_W'(psc), 1'($urandom_range(0, 1)));
    endtask

    // Residue beats carry random don't-care position and score fields
    task automatic stream_residue(input int res, input logic last);
        send_beat(FUNC_RESIDUE, POS_W'($urandom_range(0, QUERY_MAX - 1)), RES_W'(res),
                  PSC_W'($urandom_range(0, 255)), last);
    endtask

    // Hold the input idle until every result is in and the row has emptied
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LATENCY + 32) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_penalties(input int q, input int r, input int qlen);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_GAP_OPEN;
        cfg_wr_data <= CFG_W'(q);
        @(negedge aclk);
        cfg_addr    <= CFG_GAP_EXTEND;
        cfg_wr_data <= CFG_W'(r);
        @(negedge aclk);
        cfg_addr    <= CFG_QUERY_LEN;
        cfg_wr_data <= CFG_W'(qlen);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        gap_q    = PEN_W'(q);
        gap_r    = PEN_W'(r);
        qlen_reg = QLEN_W'(qlen);
        n_settings++;
    endtask

    // Change only the query length, keep the penalties
    task automatic write_qlen(input int qlen);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_QUERY_LEN;
        cfg_wr_data <= CFG_W'(qlen);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        qlen_reg = QLEN_W'(qlen);
        n_settings++;
    endtask

    // Short columns for a few residue codes, extreme scores included
    task automatic test_fill_profile();
        steady_flow = 1'b1;
        for (int p = 0; p < 16; p++) begin
            write_profile(ALPHABET_SIZE - 1, p, 127);
            for (int c = 0; c < 8; c++)
                write_profile(c, p, $urandom_range(0, 255));
        end
        write_profile(3, 15, -128);
        write_profile(4, 15, 127);
        steady_flow = 1'b0;
    endtask

    // Reset penalties over a short query, first sequence straight after reset
    task automatic test_reset_penalties();
        wait_quiet();
        write_qlen(16);
        for (int i = 0; i < 20; i++)
            stream_residue(ALPHABET_SIZE - 1, i == 19);
        for (int i = 0; i < 20; i++)
            stream_residue($urandom_range(0, 1) ? ALPHABET_SIZE - 1 : 0, i == 19);
    endtask

    task automatic test_directed();
        // Largest penalties, short sequence then a one-residue sequence
        wait_quiet();
        write_penalties(255, 255, 16);
        stream_residue(5, 1'b0);
        stream_residue(6, 1'b0);
        stream_residue(7, 1'b1);
        stream_residue(ALPHABET_SIZE - 1, 1'b1);
        // Profile write in the middle of a sequence, last flag set on it
        stream_residue(5, 1'b0);
        send_beat(FUNC_PROFILE, POS_W'(3), RES_W'(5), PSC_W'(-128), 1'b1);
        stream_residue(5, 1'b1);
        // Zero penalties with a zero query length acting as one
        wait_quiet();
        write_penalties(0, 0, 0);
        stream_residue(1, 1'b0);
        stream_residue(2, 1'b0);
        stream_residue(3, 1'b1);
        // Penalty change while a sequence is open
        stream_residue(0, 1'b0);
        stream_residue(2, 1'b0);
        wait_quiet();
        write_penalties(3, 1, 8);
        stream_residue(6, 1'b0);
        stream_residue(4, 1'b1);
    endtask

    // One register setting with random sequences and stray profile writes
    task automatic run_phase(input int q, input int r, input int qlen, input int count,
                             input bit steady);
        int sent;
        wait_quiet();
        write_penalties(q, r, qlen);
        steady_flow = steady;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 12) begin
                write_profile($urandom_range(0, ALPHABET_SIZE - 1),
                              $urandom_range(0, 1) ? $urandom_range(0, QUERY_MAX - 1)
                                                   : $urandom_range(0, 15),
                              $urandom_range(0, 255));
            end else begin
                stream_residue(pick_residue(), $urandom_range(0, 5) == 0);
                sent++;
            end
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_random();
        int q, r;
        run_phase(0, 0, 16, 90, 1'b0);
        run_phase(255, 255, 12, 90, 1'b1);
        run_phase(255, 0, 1, 90, 1'b0);
        run_phase(0, 255, 0, 60, 1'b0);
        run_phase(10, 2, 16, 60, 1'b0);
        run_phase(7, 1, 9, 40, 1'b1);
        repeat (5) begin
            q = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 16);
            r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
            run_phase(q, r, $urandom_range(2, 16), 64, $urandom_range(0, 2) == 0);
        end
    endtask

    // Result side: stall a random number of cycles before each beat
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                m_tready <= 1'b0;
                do @(posedge aclk); while (!m_tvalid);
                repeat (stall - 1) @(posedge aclk);
                @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // Compare each result beat with the oldest expected score
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_scores.size() == 0) begin
                $error("unexpected best_score beat: got %0d", m_tdata[SCORE_W-1:0]);
                n_errors++;
            end else begin
                want_score = pending_scores.pop_front();
                n_checked++;
                if (m_tdata[SCORE_W-1:0] !== want_score) begin
                    $error("best_score mismatch: expected %0d, actual %0d",
                           want_score, m_tdata[SCORE_W-1:0]);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        foreach (written_len[c])
            written_len[c] = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_fill_profile();
        test_reset_penalties();
        test_directed();
        test_random();
        wait_quiet();

        $display("Covered %0d residue beats and %0d profile writes over %0d penalty settings.",
                 n_residues, n_profile, n_settings);
        $display("Checked %0d best scores, %0d errors.", n_checked, n_errors);
        if (n_errors == 0 && pending_scores.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/swa_pkg.sv
rtl/swa_cell.sv
rtl/smith_waterman_affine_score_core.sv
rtl/swa_checker.sv
dv/tb_smith_waterman_affine_score_core.sv
